// File: hw/rtl/camt_pkg.sv
// shared types and constants for the creator/id mapping table
package camt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FETCH  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] creator_code;
    logic [31:0] entry_id;
    logic [31:0] entry_tag;
    logic [15:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  removed_count;
    logic [31:0] found_id;
    logic [31:0] found_tag;
  } result_t;

  typedef struct packed {
    logic [31:0] creator;
    logic [31:0] id;
    logic [31:0] tag;
  } rec_t;

endpackage

// File: hw/rtl/camt_ram.sv
// simple dual-port record ram, one write and one registered read per cycle
module camt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/camt_scan.sv
// request sequencer: scans the record ram one entry per cycle
module camt_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  camt_pkg::req_t              req_in,
  output logic                        busy,
  output logic                        done,
  output camt_pkg::result_t           result,
  output logic                        ram_we,
  output logic [camt_pkg::IDX_W-1:0]  ram_wr_addr,
  output camt_pkg::rec_t              ram_wr_data,
  output logic [camt_pkg::IDX_W-1:0]  ram_rd_addr,
  input  camt_pkg::rec_t              ram_rd_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                       state_r, state_nxt;
  logic [camt_pkg::CNT_W-1:0] live_r, live_nxt;
  logic                       dv_r, dv_nxt;
  logic [camt_pkg::CNT_W-1:0] ra_r, ra_nxt;
  logic [camt_pkg::CNT_W-1:0] di_r, di_nxt;
  logic [camt_pkg::CNT_W-1:0] wr_r, wr_nxt;
  logic [camt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  camt_pkg::req_t             req_r, req_nxt;

  logic                       cr_hit;
  logic                       key_hit;
  logic                       rm_hit;
  logic                       issue;
  logic                       scan_end;
  logic                       trivial;
  logic [camt_pkg::CNT_W-1:0] cnt_inc;

  assign busy = (state_r == S_SCAN);

  always_comb begin
    cr_hit   = (ram_rd_data.creator == req_r.creator_code);
    key_hit  = cr_hit && (ram_rd_data.id == req_r.entry_id);
    rm_hit   = cr_hit && ((req_r.entry_id == 32'd0) || key_hit);
    issue    = (ra_r < live_r);
    scan_end = !dv_r && !issue;
    cnt_inc  = cnt_r + 1'b1;
    // unused request code, or fetch of position zero, needs no scan
    trivial  = (req_r.req_type != camt_pkg::REQ_PUT) &&
               (req_r.req_type != camt_pkg::REQ_REMOVE) &&
               (req_r.req_type != camt_pkg::REQ_FETCH) ||
               (req_r.req_type == camt_pkg::REQ_FETCH) && (req_r.position == 16'd0);
  end

  always_comb begin
    state_nxt   = state_r;
    live_nxt    = live_r;
    dv_nxt      = dv_r;
    ra_nxt      = ra_r;
    di_nxt      = di_r;
    wr_nxt      = wr_r;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    done        = 1'b0;
    result      = '0;
    ram_we      = 1'b0;
    ram_wr_addr = wr_r[camt_pkg::IDX_W-1:0];
    ram_wr_data = ram_rd_data;
    ram_rd_addr = ra_r[camt_pkg::IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = req_in;
          ra_nxt    = '0;
          dv_nxt    = 1'b0;
          wr_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // read one entry ahead of the one being examined
        dv_nxt = issue;
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
          di_nxt = ra_r;
        end
        priority if (trivial) begin
          done          = 1'b1;
          result.status = camt_pkg::ST_NOT_FOUND;
        end else if (dv_r) begin
          unique case (req_r.req_type)
            camt_pkg::REQ_PUT: begin
              if (key_hit) begin
                ram_we          = 1'b1;
                ram_wr_addr     = di_r[camt_pkg::IDX_W-1:0];
                ram_wr_data.tag = req_r.entry_tag;
                done            = 1'b1;
                result.status   = camt_pkg::ST_OK;
              end
            end
            camt_pkg::REQ_REMOVE: begin
              if (rm_hit) begin
                cnt_nxt = cnt_inc;
              end else begin
                // close up: survivor moves down to the write pointer
                ram_we = (wr_r != di_r);
                wr_nxt = wr_r + 1'b1;
              end
            end
            camt_pkg::REQ_FETCH: begin
              if (cr_hit) begin
                cnt_nxt = cnt_inc;
                if (16'(cnt_inc) == req_r.position) begin
                  done             = 1'b1;
                  result.status    = camt_pkg::ST_OK;
                  result.found_id  = ram_rd_data.id;
                  result.found_tag = ram_rd_data.tag;
                end
              end
            end
            default: begin
            end
          endcase
        end else if (scan_end) begin
          done = 1'b1;
          unique case (req_r.req_type)
            camt_pkg::REQ_PUT: begin
              if (live_r == camt_pkg::CNT_W'(camt_pkg::TABLE_DEPTH)) begin
                result.status = camt_pkg::ST_FULL;
              end else begin
                ram_we              = 1'b1;
                ram_wr_addr         = live_r[camt_pkg::IDX_W-1:0];
                ram_wr_data.creator = req_r.creator_code;
                ram_wr_data.id      = req_r.entry_id;
                ram_wr_data.tag     = req_r.entry_tag;
                live_nxt            = live_r + 1'b1;
                result.status       = camt_pkg::ST_OK;
              end
            end
            camt_pkg::REQ_REMOVE: begin
              live_nxt             = wr_r;
              result.status        = (cnt_r != '0) ? camt_pkg::ST_OK
                                                   : camt_pkg::ST_NOT_FOUND;
              result.removed_count = 7'(cnt_r);
            end
            default: begin
              result.status = camt_pkg::ST_NOT_FOUND;
            end
          endcase
        end
        if (done) begin
          dv_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r  <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      dv_r    <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r  <= ra_nxt;
    di_r  <= di_nxt;
    wr_r  <= wr_nxt;
    cnt_r <= cnt_nxt;
    req_r <= req_nxt;
  end

endmodule

// File: hw/rtl/creator_app_mapping_table.sv
// top level of the creator/id mapping table
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+--------------------------
//  request  | start, busy, in_*                       | edge with start & !busy
//  result   | out_valid, out_*                        | every edge with out_valid
//
//  a request scans the live records one per cycle through the record ram
//  (one read, one write port, registered read data); a put or fetch that hits
//  ends the scan early, and unused codes and fetch of position zero need no
//  scan. the result strobe comes in the same cycle that busy falls.
//  rst_n is synchronous and empties the table at once.
//  results cannot be stalled; a new request may start while one is shown.
module creator_app_mapping_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_creator_code,
  input  logic [31:0] in_entry_id,
  input  logic [31:0] in_entry_tag,
  input  logic [15:0] in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [6:0]  out_removed_count,
  output logic [31:0] out_found_id,
  output logic [31:0] out_found_tag
);

  camt_pkg::req_t                req;
  camt_pkg::result_t             scan_result;
  camt_pkg::result_t             result_r;
  logic                          scan_done;
  logic                          out_valid_r;
  logic                          ram_we;
  logic [camt_pkg::IDX_W-1:0]    ram_wr_addr;
  logic [camt_pkg::IDX_W-1:0]    ram_rd_addr;
  camt_pkg::rec_t                ram_wr_data;
  camt_pkg::rec_t                ram_rd_data;

  always_comb begin
    req.req_type     = in_req_type;
    req.creator_code = in_creator_code;
    req.entry_id     = in_entry_id;
    req.entry_tag    = in_entry_tag;
    req.position     = in_position;
  end

  camt_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req_in      (req),
    .busy        (busy),
    .done        (scan_done),
    .result      (scan_result),
    .ram_we      (ram_we),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  camt_ram #(
    .DEPTH (camt_pkg::TABLE_DEPTH),
    .WIDTH ($bits(camt_pkg::rec_t))
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= scan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      result_r <= scan_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = result_r.status;
  assign out_removed_count = result_r.removed_count;
  assign out_found_id      = result_r.found_id;
  assign out_found_tag     = result_r.found_tag;

endmodule

// File: hw/rtl/camt_checker.sv
// port-level checks for the creator/id mapping table, bound to the top level
module camt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [6:0]  out_removed_count,
  input logic [31:0] out_found_id,
  input logic [31:0] out_found_tag
);

  // an accepted request always raises busy in the cycle after its transfer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request transfer did not raise busy");

  // exactly one result per request: strobe comes with the fall of busy
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result transfer");

  a_strobe_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result transfer without a finished request");

  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != camt_pkg::ST_OK |->
      out_found_id == 32'd0 && out_found_tag == 32'd0 && out_removed_count == 7'd0)
    else $error("failed request carries nonzero fields");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

endmodule

bind creator_app_mapping_table camt_checker u_camt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_removed_count (out_removed_count),
  .out_found_id      (out_found_id),
  .out_found_tag     (out_found_tag)
);
